@@ hw/rtl/hfr_pkg.sv @@
// ---------------------------------------------------------------------------
// hfr_pkg: shared types and constants of the hex frame receiver
// Word formats, configuration register indexes, frame positions and the
// ASCII hex digit decoder.
// ---------------------------------------------------------------------------
package hfr_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE    = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] OWN_ADDRESS_RST = 8'h00;
  localparam logic [7:0] START_BYTE_RST  = 8'h01;
  localparam logic [7:0] END_BYTE_RST    = 8'h02;

  // Special byte values.
  localparam logic [7:0] BROADCAST_ADDR = 8'h2A;
  localparam logic [7:0] IDLE_LOW_BYTE  = 8'h00;
  localparam logic [7:0] IDLE_HIGH_BYTE = 8'hFF;

  // Input word command codes.
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Position inside a frame.
  typedef enum logic [2:0] {
    POS_HUNT   = 3'd0,
    POS_ADDR   = 3'd1,
    POS_FUNC   = 3'd2,
    POS_CMD_HI = 3'd3,
    POS_CMD_LO = 3'd4,
    POS_SUM_HI = 3'd5,
    POS_SUM_LO = 3'd6,
    POS_END    = 3'd7
  } pos_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic        is_broadcast;
    logic [7:0]  frame_address;
    logic [7:0]  function_code;
    logic [7:0]  command_value;
    logic        checksum_error;
    logic        framing_error;
    logic [31:0] checksum_error_count;
    logic [31:0] framing_error_count;
  } out_word_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] start_byte;
    logic [7:0] end_byte;
  } cfg_t;

  // Value of an upper-case ASCII hex digit; anything else decodes as zero.
  function automatic logic [3:0] hex_digit_value(input logic [7:0] ch);
    logic [3:0] val;
    val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      val = ch[3:0];
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      val = 4'(ch - 8'h41 + 8'd10);
    end
    return val;
  endfunction

endpackage

@@ hw/rtl/hfr_if.sv @@
// ---------------------------------------------------------------------------
// hfr_if: valid/ready channels of the hex frame receiver
// One interface for the input word channel and one for the result channel.
// ---------------------------------------------------------------------------
interface hfr_in_if;
  import hfr_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hfr_out_if;
  import hfr_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/hfr_in_reg.sv @@
// ---------------------------------------------------------------------------
// hfr_in_reg: input word register
// Captures one input word and holds it until the parser takes it. A new
// word is accepted in the same cycle the held one is taken.
// ---------------------------------------------------------------------------
module hfr_in_reg (
  input  logic             clk,
  input  logic             rst,
  hfr_in_if.sink           byte_in,
  input  logic             take,
  output logic             held_valid,
  output hfr_pkg::in_word_t held_word
);
  import hfr_pkg::*;

  // Ready when empty or when the held word leaves this cycle.
  assign byte_in.ready = !held_valid || take;

  // Valid flag of the held word.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      held_word <= byte_in.data;
    end
  end

endmodule

@@ hw/rtl/hfr_parser.sv @@
// ---------------------------------------------------------------------------
// hfr_parser: frame parser and error counters
// Advances the frame position for each word taken, collects the frame
// fields and the running checksum, and forms the result at the end byte.
// ---------------------------------------------------------------------------
module hfr_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  hfr_pkg::in_word_t word,
  input  hfr_pkg::cfg_t     cfg,
  output logic              res_valid,
  output hfr_pkg::out_word_t res
);
  import hfr_pkg::*;

  pos_t        byte_position;
  pos_t        byte_position_next;
  logic [7:0]  held_address;
  logic [7:0]  held_address_next;
  logic [7:0]  held_function;
  logic [7:0]  held_function_next;
  logic [7:0]  held_command;
  logic [7:0]  held_command_next;
  logic [7:0]  received_sum;
  logic [7:0]  received_sum_next;
  logic [7:0]  computed_sum;
  logic [7:0]  computed_sum_next;
  logic [31:0] sum_error_total;
  logic [31:0] sum_error_total_next;
  logic [31:0] frame_error_total;
  logic [31:0] frame_error_total_next;

  logic [7:0]  b;
  logic        is_start;
  logic        byte_live;
  pos_t        eff_pos;
  logic [3:0]  digit;
  logic        cs_bad;
  logic        fr_bad;
  logic        addr_ok;

  // Byte qualification: idle fill bytes are dropped, hunting needs a start.
  assign b         = word.rx_byte;
  assign is_start  = (b == cfg.start_byte);
  assign byte_live = take && (word.cmd == CMD_BYTE) &&
                     (b != IDLE_LOW_BYTE) && (b != IDLE_HIGH_BYTE) &&
                     ((byte_position != POS_HUNT) || is_start);
  assign eff_pos   = is_start ? POS_HUNT : byte_position;
  assign digit     = hex_digit_value(b);

  // Frame checks at the end byte.
  assign cs_bad  = (received_sum != computed_sum);
  assign fr_bad  = (b != cfg.end_byte);
  assign addr_ok = (held_address == cfg.own_address) || (held_address == BROADCAST_ADDR);

  // Next frame position.
  always_comb begin
    byte_position_next = byte_position;
    if (byte_live) begin
      unique case (eff_pos)
        POS_HUNT:   byte_position_next = POS_ADDR;
        POS_ADDR:   byte_position_next = POS_FUNC;
        POS_FUNC:   byte_position_next = POS_CMD_HI;
        POS_CMD_HI: byte_position_next = POS_CMD_LO;
        POS_CMD_LO: byte_position_next = POS_SUM_HI;
        POS_SUM_HI: byte_position_next = POS_SUM_LO;
        POS_SUM_LO: byte_position_next = POS_END;
        POS_END:    byte_position_next = POS_HUNT;
        default:    byte_position_next = POS_HUNT;
      endcase
    end
  end

  // Field capture, checksum, counters and result.
  always_comb begin
    held_address_next      = held_address;
    held_function_next     = held_function;
    held_command_next      = held_command;
    received_sum_next      = received_sum;
    computed_sum_next      = computed_sum;
    sum_error_total_next   = sum_error_total;
    frame_error_total_next = frame_error_total;
    res_valid              = 1'b0;

    if (take && (word.cmd == CMD_CLEAR)) begin
      sum_error_total_next   = '0;
      frame_error_total_next = '0;
    end else if (byte_live) begin
      unique case (eff_pos)
        POS_HUNT: begin
          computed_sum_next = '0;
        end
        POS_ADDR: begin
          held_address_next = b;
          computed_sum_next = computed_sum + b;
        end
        POS_FUNC: begin
          held_function_next = b;
          computed_sum_next  = computed_sum + b;
        end
        POS_CMD_HI: begin
          held_command_next = {digit, 4'd0};
          computed_sum_next = computed_sum + b;
        end
        POS_CMD_LO: begin
          held_command_next = {held_command[7:4], digit};
          computed_sum_next = computed_sum + b;
        end
        POS_SUM_HI: begin
          received_sum_next = {digit, 4'd0};
        end
        POS_SUM_LO: begin
          received_sum_next = {received_sum[7:4], digit};
        end
        default: begin
          res_valid = 1'b1;
          if (cs_bad) begin
            sum_error_total_next = sum_error_total + 32'd1;
          end
          if (fr_bad) begin
            frame_error_total_next = frame_error_total + 32'd1;
          end
        end
      endcase
    end

    res.accepted             = !cs_bad && !fr_bad && addr_ok;
    res.is_broadcast         = (held_address == BROADCAST_ADDR);
    res.frame_address        = held_address;
    res.function_code        = held_function;
    res.command_value        = held_command;
    res.checksum_error       = cs_bad;
    res.framing_error        = fr_bad;
    res.checksum_error_count = sum_error_total_next;
    res.framing_error_count  = frame_error_total_next;
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= POS_HUNT;
      sum_error_total   <= '0;
      frame_error_total <= '0;
    end else begin
      byte_position     <= byte_position_next;
      sum_error_total   <= sum_error_total_next;
      frame_error_total <= frame_error_total_next;
    end
  end

  // Frame fields.
  always_ff @(posedge clk) begin
    held_address  <= held_address_next;
    held_function <= held_function_next;
    held_command  <= held_command_next;
    received_sum  <= received_sum_next;
    computed_sum  <= computed_sum_next;
  end

endmodule

@@ hw/rtl/hex_frame_receiver.sv @@
// ---------------------------------------------------------------------------
// hex_frame_receiver: byte-serial hex frame receiver
// Parses start/address/function/hex command/hex checksum/end frames and
// keeps wrapping checksum and framing error counters.
// ---------------------------------------------------------------------------
// Usage:
//   byte_in carries one word per handshake: cmd 0 with a received byte, or
//   cmd 1 to clear both error counters. result_out carries one word per
//   completed frame, at the end-byte position; other words give no result.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) sets the node
//   address and the start and end markers; write it only while idle.
//   A word is registered in the input register on acceptance and parsed
//   when the parser takes it, which loads its result into result_out.
//   Throughput: one word per cycle while result_out is not stalled.
//   When result_out stalls, the held result waits and the input register
//   keeps one word; byte_in then deasserts ready until the result is taken.
//   Reset clears the frame position, both counters and all valid flags,
//   and loads the default markers and address.
// ---------------------------------------------------------------------------
module hex_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  hfr_in_if.sink                         byte_in,
  hfr_out_if.source                      result_out,
  input  logic                           cfg_we,
  input  logic [hfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import hfr_pkg::*;

  cfg_t      cfg;
  logic      held_valid;
  in_word_t  held_word;
  logic      take;
  logic      res_valid;
  out_word_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address <= OWN_ADDRESS_RST;
      cfg.start_byte  <= START_BYTE_RST;
      cfg.end_byte    <= END_BYTE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_OWN_ADDRESS) begin
        cfg.own_address <= cfg_wdata;
      end else if (cfg_index == CFG_START_BYTE) begin
        cfg.start_byte <= cfg_wdata;
      end else if (cfg_index == CFG_END_BYTE) begin
        cfg.end_byte <= cfg_wdata;
      end
    end
  end

  // Input word register.
  hfr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .take       (take),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  // The parser takes a word when the result register has room for its result.
  assign take = held_valid && (!result_out.valid || result_out.ready);

  hfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .word      (held_word),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (take) begin
      result_out.valid <= res_valid;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      result_out.data <= res;
    end
  end

  // A frame is never accepted with an error flag set.
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> !(result_out.data.accepted &&
      (result_out.data.checksum_error || result_out.data.framing_error)))
    else $error("accepted result carries an error flag");

  // A result formed by the parser shows up on the output next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    take && res_valid |=> result_out.valid)
    else $error("parser result was lost");

  // Input backpressure only while a word is held behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_in.ready |-> held_valid && result_out.valid && !result_out.ready)
    else $error("input stalled without a blocked result");

endmodule
